FILE: rtl/eaft_pkg.sv
package eaft_pkg;

  // operation codes carried by an input word
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // easing curve selection
  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_INOUT  = 2'd1,
    CURVE_IN     = 2'd2,
    CURVE_OUT    = 2'd3
  } curve_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DURATION = 2'd0,
    REG_REPEAT   = 2'd1,
    REG_REVERSE  = 2'd2,
    REG_CURVE    = 2'd3
  } reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_SUB,
    S_SQRT,
    S_FIN,
    S_FLUSH
  } state_e;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned REPEAT_W = 16;
  localparam int unsigned REPS_W   = 17;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned IDX_W    = 2;

endpackage

FILE: rtl/eased_animation_frame_timer_core.sv
// Start, stop, no-op and idle tick words go from accept straight to the flush state;
// a running tick with a nonzero duration runs the bit-serial divider (linear) or the
// divider, square and bit-serial square root (circular), sharing one subtract/compare unit.
// One word is in work at a time, the next taken the cycle after its result loads;
// a held result stalls only the next finish.
// Reset (rst_ni low, async) clears config, control and repeat state and idles the timer.
module eased_animation_frame_timer_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_write_i,
  input  logic [eaft_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [eaft_pkg::CFG_W-1:0]        cfg_data_i,
  // input word
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic [eaft_pkg::TIME_W-1:0]       now_ticks_i,
  // result word
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              frame_valid_o,
  output logic [FRAC_BITS:0]                frame_value_o,
  output logic                              finished_o,
  output logic                              running_o
);

  localparam int unsigned FW  = FRAC_BITS + 1;        // Q1.F value width
  localparam int unsigned VW  = 2 * FRAC_BITS + 2;    // radicand width (even)
  localparam int unsigned SRW = FRAC_BITS + 1;        // square root remainder
  localparam int unsigned RW  = FRAC_BITS + 3;        // square root trial width
  localparam int unsigned DW  = eaft_pkg::TIME_W + 1; // division trial width
  localparam int unsigned AW  = (RW > DW) ? RW : DW;  // shared unit width
  localparam int unsigned CW  = $clog2(FRAC_BITS + 1);

  localparam logic [FW-1:0]   ONE     = FW'(1) << FRAC_BITS;
  localparam logic [FW-1:0]   HALF    = FW'(1) << (FRAC_BITS - 1);
  localparam logic [FW:0]     TWO     = (FW + 1)'(1) << (FRAC_BITS + 1);
  localparam logic [VW-1:0]   ONE_SQ  = VW'(1) << (2 * FRAC_BITS);
  localparam logic [CW-1:0]   LAST    = CW'(FRAC_BITS);

  // configuration registers
  logic [eaft_pkg::TIME_W-1:0]   dur_q;
  logic [eaft_pkg::REPEAT_W-1:0] rep_cnt_q;
  logic                          rev_q;
  logic [1:0]                    curve_q;

  // timer state
  logic [eaft_pkg::TIME_W-1:0]   start_q, start_d;
  logic [eaft_pkg::REPS_W-1:0]   reps_q, reps_d;
  logic                          active_q, active_d;

  // sequencer and datapath
  eaft_pkg::state_e              state_q, state_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [eaft_pkg::TIME_W-1:0]   now_q, now_d;
  logic                          end_q, end_d;
  logic                          fval_q, fval_d;
  logic [eaft_pkg::TIME_W-1:0]   div_rem_q, div_rem_d;
  logic [FW-1:0]                 quo_q, quo_d;
  logic [VW-1:0]                 sq_q, sq_d;
  logic [VW-1:0]                 rad_q, rad_d;
  logic [SRW-1:0]                sqrt_rem_q, sqrt_rem_d;
  logic [FW-1:0]                 root_q, root_d;

  // staged result and output register
  logic                          res_fv_q, res_fv_d;
  logic [FW-1:0]                 res_val_q, res_val_d;
  logic                          res_fin_q, res_fin_d;
  logic                          res_run_q, res_run_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_load;
  logic                          o_fv_q, o_fin_q, o_run_q;
  logic [FW-1:0]                 o_val_q;

  // shared subtract/compare unit
  logic [AW-1:0]                 alu_a, alu_b, alu_diff;
  logic                          alu_ge;

  // combinational helpers
  logic                          in_acc;
  logic [eaft_pkg::TIME_W-1:0]   elapsed_raw;
  logic                          period_end;
  logic [FW-1:0]                 ease_y;
  logic [FW:0]                   x_dbl;
  logic [FW-1:0]                 eased;
  logic [FW-1:0]                 frame;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != eaft_pkg::S_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q     <= '0;
      rep_cnt_q <= '0;
      rev_q     <= 1'b0;
      curve_q   <= '0;
    end else if (cfg_write_i) begin
      case (eaft_pkg::reg_e'(cfg_index_i))
        eaft_pkg::REG_DURATION: dur_q     <= cfg_data_i;
        eaft_pkg::REG_REPEAT:   rep_cnt_q <= cfg_data_i[eaft_pkg::REPEAT_W-1:0];
        eaft_pkg::REG_REVERSE:  rev_q     <= cfg_data_i[0];
        eaft_pkg::REG_CURVE:    curve_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // shared unit: operands picked by the sequencer state
  always_comb begin
    case (state_q)
      eaft_pkg::S_DIV: begin
        alu_a = (cnt_q == '0) ? AW'(div_rem_q) : AW'({div_rem_q, 1'b0});
        alu_b = AW'(dur_q);
      end
      eaft_pkg::S_SQRT: begin
        alu_a = AW'({sqrt_rem_q, rad_q[VW-1 -: 2]});
        alu_b = AW'({root_q, 2'b01});
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
    alu_ge   = (alu_a >= alu_b);
    alu_diff = alu_a - alu_b;
  end

  // elapsed time, wrapped; period end when it reaches the duration
  assign elapsed_raw = now_ticks_i - start_q;
  assign period_end  = (elapsed_raw >= dur_q);

  // argument of the square root term
  assign x_dbl = {quo_q, 1'b0};
  always_comb begin
    case (eaft_pkg::curve_e'(curve_q))
      eaft_pkg::CURVE_IN:    ease_y = quo_q;
      eaft_pkg::CURVE_OUT:   ease_y = ONE - quo_q;
      eaft_pkg::CURVE_INOUT: ease_y = (quo_q < HALF) ? x_dbl[FW-1:0]
                                                     : FW'(TWO - x_dbl);
      default:               ease_y = quo_q;
    endcase
  end

  // eased value from the root (the quotient when linear), then reverse on even repeats
  always_comb begin
    case (eaft_pkg::curve_e'(curve_q))
      eaft_pkg::CURVE_IN:    eased = ONE - root_q;
      eaft_pkg::CURVE_OUT:   eased = root_q;
      eaft_pkg::CURVE_INOUT: eased = (quo_q < HALF) ? ((ONE - root_q) >> 1)
                                                    : ((root_q >> 1) + HALF);
      default:               eased = quo_q;
    endcase
    frame = (rev_q && !reps_q[0]) ? (ONE - eased) : eased;
  end

  assign out_load = (state_q == eaft_pkg::S_FLUSH) && (!out_valid_q || !out_stall_i);

  // sequencer: next state and datapath updates
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    now_d      = now_q;
    end_d      = end_q;
    fval_d     = fval_q;
    div_rem_d  = div_rem_q;
    quo_d      = quo_q;
    sq_d       = sq_q;
    rad_d      = rad_q;
    sqrt_rem_d = sqrt_rem_q;
    root_d     = root_q;
    start_d    = start_q;
    reps_d     = reps_q;
    active_d   = active_q;
    res_fv_d   = res_fv_q;
    res_val_d  = res_val_q;
    res_fin_d  = res_fin_q;
    res_run_d  = res_run_q;

    case (state_q)
      eaft_pkg::S_IDLE: begin
        if (in_acc) begin
          now_d     = now_ticks_i;
          res_fv_d  = 1'b0;
          res_val_d = '0;
          res_fin_d = 1'b0;
          res_run_d = active_q;
          state_d   = eaft_pkg::S_FLUSH;
          case (eaft_pkg::op_e'(operation_i))
            eaft_pkg::OP_START: begin
              start_d   = now_ticks_i;
              reps_d    = rev_q ? {rep_cnt_q, 1'b1} : {1'b0, rep_cnt_q};
              active_d  = 1'b1;
              res_run_d = 1'b1;
            end
            eaft_pkg::OP_STOP: begin
              active_d  = 1'b0;
              res_run_d = 1'b0;
            end
            eaft_pkg::OP_TICK: begin
              if (active_q) begin
                end_d     = period_end;
                fval_d    = (dur_q != '0);
                div_rem_d = period_end ? dur_q : elapsed_raw;
                quo_d     = '0;
                cnt_d     = '0;
                state_d   = (dur_q != '0) ? eaft_pkg::S_DIV : eaft_pkg::S_FIN;
              end
            end
            default: ;
          endcase
        end
      end

      // restoring division, one quotient bit per cycle
      eaft_pkg::S_DIV: begin
        div_rem_d = alu_ge ? alu_diff[eaft_pkg::TIME_W-1:0]
                           : alu_a[eaft_pkg::TIME_W-1:0];
        quo_d     = {quo_q[FW-2:0], alu_ge};
        cnt_d     = cnt_q + CW'(1);
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = (eaft_pkg::curve_e'(curve_q) == eaft_pkg::CURVE_LINEAR)
                    ? eaft_pkg::S_FIN : eaft_pkg::S_MUL;
        end
      end

      eaft_pkg::S_MUL: begin
        sq_d    = ease_y * ease_y;
        state_d = eaft_pkg::S_SUB;
      end

      eaft_pkg::S_SUB: begin
        rad_d      = ONE_SQ - sq_q;
        sqrt_rem_d = '0;
        root_d     = '0;
        cnt_d      = '0;
        state_d    = eaft_pkg::S_SQRT;
      end

      // digit-by-digit square root, one root bit per cycle
      eaft_pkg::S_SQRT: begin
        sqrt_rem_d = alu_ge ? alu_diff[SRW-1:0] : alu_a[SRW-1:0];
        root_d     = {root_q[FW-2:0], alu_ge};
        rad_d      = rad_q << 2;
        cnt_d      = cnt_q + CW'(1);
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = eaft_pkg::S_FIN;
        end
      end

      // frame value and period bookkeeping
      eaft_pkg::S_FIN: begin
        res_fv_d  = fval_q;
        res_val_d = fval_q ? frame : '0;
        res_fin_d = 1'b0;
        res_run_d = 1'b1;
        if (end_q) begin
          if (reps_q == '0) begin
            active_d  = 1'b0;
            res_fin_d = 1'b1;
            res_run_d = 1'b0;
          end else begin
            reps_d  = reps_q - eaft_pkg::REPS_W'(1);
            start_d = now_q;
          end
        end
        state_d = eaft_pkg::S_FLUSH;
      end

      eaft_pkg::S_FLUSH: begin
        if (out_load) state_d = eaft_pkg::S_IDLE;
      end

      default: state_d = eaft_pkg::S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eaft_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      reps_q      <= '0;
      active_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      start_q     <= start_d;
      reps_q      <= reps_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    end_q      <= end_d;
    fval_q     <= fval_d;
    div_rem_q  <= div_rem_d;
    quo_q      <= quo_d;
    sq_q       <= sq_d;
    rad_q      <= rad_d;
    sqrt_rem_q <= sqrt_rem_d;
    root_q     <= root_d;
    res_fv_q   <= res_fv_d;
    res_val_q  <= res_val_d;
    res_fin_q  <= res_fin_d;
    res_run_q  <= res_run_d;
    if (out_load) begin
      o_fv_q  <= res_fv_q;
      o_val_q <= res_val_q;
      o_fin_q <= res_fin_q;
      o_run_q <= res_run_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_valid_o = o_fv_q;
  assign frame_value_o = o_val_q;
  assign finished_o    = o_fin_q;
  assign running_o     = o_run_q;

endmodule

FILE: rtl/eaft_checker.sv
module eaft_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               frame_valid_o,
  input logic [FRAC_BITS:0] frame_value_o,
  input logic               finished_o,
  input logic               running_o
);

  // an accepted word leaves the input stalled in the cycle after
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a word was accepted");

  // a result word that is held keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(frame_value_o) && $stable(frame_valid_o)
       && $stable(finished_o) && $stable(running_o)))
    else $error("stalled result word changed");

  // no frame means a zero value
  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_valid_o) |-> (frame_value_o == '0))
    else $error("frame value set without a frame");

  // a completing tick leaves the timer stopped
  a_fin_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> !running_o)
    else $error("finished while still running");

  // frame value never exceeds one
  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_value_o <= ((FRAC_BITS + 1)'(1) << FRAC_BITS)))
    else $error("frame value above one");

endmodule

bind eased_animation_frame_timer_core eaft_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_eaft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .frame_valid_o (frame_valid_o),
  .frame_value_o (frame_value_o),
  .finished_o    (finished_o),
  .running_o     (running_o)
);

FILE: verif/eaft_frame_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both word channels of the frame timer,
// models the timer, and compares every result word against the model.
module eaft_frame_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_write_i,
  input  logic [eaft_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [eaft_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    operation_i,
  input  logic [eaft_pkg::TIME_W-1:0]   now_ticks_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          frame_valid_i,
  input  logic [FRAC_BITS:0]            frame_value_i,
  input  logic                          finished_i,
  input  logic                          running_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            checked_o
);

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic                 frame_valid;
    logic [FRAC_BITS:0]   frame_value;
    logic                 finished;
    logic                 running;
  } frame_word_t;

  // shadow copy of the register file
  logic [31:0]                 dur_ticks;
  logic [15:0]                 rep_count;
  logic                        reverse_on;
  eaft_pkg::curve_e            curve_sel;

  // shadow timer state
  logic [31:0]                 period_begin;
  logic [eaft_pkg::REPS_W-1:0] periods_left;
  logic                        timer_on;

  frame_word_t       frames_due[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
    checked_o = 0;
  end

  // floor square root, one result bit per pass
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] rem, root, probe;
    rem   = v;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] circ_in(input logic [63:0] x);
    return ONE - root_floor(ONE * ONE - x * x);
  endfunction

  function automatic logic [63:0] circ_out(input logic [63:0] x);
    logic [63:0] d;
    d = ONE - x;
    return root_floor(ONE * ONE - d * d);
  endfunction

  function automatic logic [63:0] eased(input logic [63:0] x);
    case (curve_sel)
      eaft_pkg::CURVE_INOUT: begin
        if (x < ONE / 2) return circ_in(2 * x) >> 1;
        return (circ_out(2 * x - ONE) >> 1) + ONE / 2;
      end
      eaft_pkg::CURVE_IN:  return circ_in(x);
      eaft_pkg::CURVE_OUT: return circ_out(x);
      default:             return x;
    endcase
  endfunction

  // one input word through the timer; updates the shadow state
  function automatic frame_word_t advance_timer(input eaft_pkg::op_e op,
                                                input logic [31:0] now);
    frame_word_t w;
    logic [31:0] elapsed;
    logic [63:0] frac, frame;
    w     = '0;
    frame = '0;
    case (op)
      eaft_pkg::OP_START: begin
        period_begin = now;
        periods_left = reverse_on ? {rep_count, 1'b1} : {1'b0, rep_count};
        timer_on     = 1'b1;
      end
      eaft_pkg::OP_STOP: timer_on = 1'b0;
      eaft_pkg::OP_TICK: begin
        if (timer_on) begin
          elapsed = now - period_begin;
          if (elapsed > dur_ticks) elapsed = dur_ticks;
          if (dur_ticks != 0) begin
            frac  = ({32'd0, elapsed} << FRAC_BITS) / {32'd0, dur_ticks};
            frame = eased(frac);
            // backwards on even remaining periods
            if (reverse_on && !periods_left[0]) frame = ONE - frame;
            w.frame_valid = 1'b1;
          end
          // period end: next period or done
          if (elapsed == dur_ticks) begin
            if (periods_left == 0) begin
              timer_on   = 1'b0;
              w.finished = 1'b1;
            end else begin
              periods_left = periods_left - 1'b1;
              period_begin = now;
            end
          end
        end
      end
      default: ;
    endcase
    w.frame_value = frame[FRAC_BITS:0];
    w.running     = timer_on;
    return w;
  endfunction

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch at result %0d: %s", $time, checked_o, what);
    errors_o++;
  endtask

  // sample config, input and result channels on each edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_word_t want;
    if (!rst_ni) begin
      dur_ticks    = '0;
      rep_count    = '0;
      reverse_on   = 1'b0;
      curve_sel    = eaft_pkg::CURVE_LINEAR;
      period_begin = '0;
      periods_left = '0;
      timer_on     = 1'b0;
      frames_due.delete();
    end else begin
      if (cfg_write_i) begin
        case (eaft_pkg::reg_e'(cfg_index_i))
          eaft_pkg::REG_DURATION: dur_ticks  = cfg_data_i[31:0];
          eaft_pkg::REG_REPEAT:   rep_count  = cfg_data_i[15:0];
          eaft_pkg::REG_REVERSE:  reverse_on = cfg_data_i[0];
          eaft_pkg::REG_CURVE:    curve_sel  = eaft_pkg::curve_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        frames_due.push_back(advance_timer(eaft_pkg::op_e'(operation_i), now_ticks_i));
      if (out_valid_i && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          note_mismatch("result word with nothing expected");
        end else begin
          want = frames_due.pop_front();
          if (frame_valid_i !== want.frame_valid)
            note_mismatch($sformatf("frame_valid got %0d want %0d",
                                    frame_valid_i, want.frame_valid));
          if (frame_value_i !== want.frame_value)
            note_mismatch($sformatf("frame_value got %0d want %0d",
                                    frame_value_i, want.frame_value));
          if (finished_i !== want.finished)
            note_mismatch($sformatf("finished got %0d want %0d",
                                    finished_i, want.finished));
          if (running_i !== want.running)
            note_mismatch($sformatf("running got %0d want %0d",
                                    running_i, want.running));
        end
        checked_o++;
      end
    end
    pending_o = frames_due.size();
  end

endmodule

FILE: verif/eased_animation_frame_timer_core_tb.sv
`timescale 1ns / 1ps

module eased_animation_frame_timer_core_tb;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int          WORD_TARGET = 850;
  localparam int          SETTLE      = 45;      // longest word latency plus margin
  localparam int          CYCLE_LIMIT = 400000;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_write_i;
  logic [eaft_pkg::IDX_W-1:0]        cfg_index_i;
  logic [eaft_pkg::CFG_W-1:0]        cfg_data_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [1:0]                        operation_i;
  logic [eaft_pkg::TIME_W-1:0]       now_ticks_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic                              frame_valid_o;
  logic [FRAC_BITS:0]                frame_value_o;
  logic                              finished_o;
  logic                              running_o;

  int          errors;
  int          pending;
  int          checked;
  int          words_sent;
  int          settings_used;
  int          cycle_count;
  logic        idle_on;
  logic [31:0] now_t;

  eased_animation_frame_timer_core #(.FRAC_BITS(FRAC_BITS)) DUT (.*);

  eaft_frame_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_write_i   (cfg_write_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .operation_i   (operation_i),
    .now_ticks_i   (now_ticks_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_valid_i (frame_valid_o),
    .frame_value_i (frame_value_o),
    .finished_i    (finished_o),
    .running_i     (running_o),
    .errors_o      (errors),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("eased_animation_frame_timer_core_tb: done, errors");
      $finish;
    end
  end

  // result side: a random stall ahead of each result word while idle_on is set
  initial begin : result_pace
    int hold;
    out_stall_i = 1'b0;
    forever begin
      hold = idle_on ? $urandom_range(0, 4) : 0;
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // one input word, after a random gap while idle_on is set
  task automatic send_word(input eaft_pkg::op_e op, input logic [31:0] now);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    now_ticks_i <= now;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // hold off until every result is back and the core has gone quiet
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // write all four registers; unused upper bits carry junk
  task automatic write_regs(input logic [31:0] dur, input logic [15:0] rep,
                            input logic rev, input eaft_pkg::curve_e curve);
    logic [31:0] junk;
    drain();
    junk = $urandom();
    @(negedge clk_i);
    cfg_write_i <= 1'b1;
    cfg_index_i <= eaft_pkg::REG_DURATION;
    cfg_data_i  <= dur;
    @(negedge clk_i);
    cfg_index_i <= eaft_pkg::REG_REPEAT;
    cfg_data_i  <= {junk[31:16], rep};
    @(negedge clk_i);
    cfg_index_i <= eaft_pkg::REG_REVERSE;
    cfg_data_i  <= {junk[31:1], rev};
    @(negedge clk_i);
    cfg_index_i <= eaft_pkg::REG_CURVE;
    cfg_data_i  <= {junk[31:2], curve};
    @(negedge clk_i);
    cfg_write_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] time_step(input logic [31:0] dur);
    if (dur == 0) return $urandom_range(0, 50);
    if (dur <= 1000) return $urandom_range(0, dur / 3 + 1);
    return $urandom() >> $urandom_range(0, 6);
  endfunction

  // edge cases: wrap of the time base, clamping, restart, zero and unit duration
  task automatic directed_words();
    idle_on = 1'b1;
    write_regs(32'd100, 16'd1, 1'b0, eaft_pkg::CURVE_LINEAR);
    send_word(eaft_pkg::OP_TICK,  32'h0000_0000);   // idle tick
    send_word(eaft_pkg::OP_NOP,   32'hFFFF_FFFF);
    send_word(eaft_pkg::OP_START, 32'hFFFF_FFC0);
    send_word(eaft_pkg::OP_TICK,  32'hFFFF_FFF0);
    send_word(eaft_pkg::OP_TICK,  32'h0000_0024);   // wraps, ends first period
    send_word(eaft_pkg::OP_TICK,  32'h0000_0024);   // zero elapsed
    send_word(eaft_pkg::OP_NOP,   32'h0000_0030);
    send_word(eaft_pkg::OP_TICK,  32'h0000_0020);   // behind start: clamped, finishes
    send_word(eaft_pkg::OP_TICK,  32'h0000_0100);
    send_word(eaft_pkg::OP_START, 32'h0000_0200);
    send_word(eaft_pkg::OP_STOP,  32'h0000_0210);
    send_word(eaft_pkg::OP_TICK,  32'h0000_0220);

    write_regs(32'hFFFF_FFFF, 16'hFFFF, 1'b1, eaft_pkg::CURVE_OUT);
    send_word(eaft_pkg::OP_START, 32'h0000_0000);
    send_word(eaft_pkg::OP_TICK,  32'h7FFF_FFFF);
    send_word(eaft_pkg::OP_TICK,  32'hFFFF_FFFF);   // full period
    send_word(eaft_pkg::OP_TICK,  32'hFFFF_FFFE);   // wrapped, reversed period
    send_word(eaft_pkg::OP_START, 32'h1234_5678);   // restart while running
    send_word(eaft_pkg::OP_STOP,  32'h1234_5679);

    write_regs(32'd0, 16'd2, 1'b0, eaft_pkg::CURVE_IN);
    send_word(eaft_pkg::OP_START, 32'd5);
    send_word(eaft_pkg::OP_TICK,  32'd6);
    send_word(eaft_pkg::OP_TICK,  32'd7);
    send_word(eaft_pkg::OP_TICK,  32'd8);           // third period ends, finishes

    write_regs(32'd1, 16'd0, 1'b1, eaft_pkg::CURVE_INOUT);
    send_word(eaft_pkg::OP_START, 32'd9);
    send_word(eaft_pkg::OP_TICK,  32'd9);
    send_word(eaft_pkg::OP_TICK,  32'd10);
  endtask

  // one random setting followed by a run of mostly well-formed animation words
  task automatic random_phase();
    logic [31:0] dur;
    logic [15:0] rep;
    int          n_words;
    int          pick;
    case ($urandom_range(0, 9))
      0:       dur = 32'd0;
      1:       dur = 32'd1;
      2:       dur = $urandom();
      3:       dur = 32'hFFFF_FFFF;
      default: dur = $urandom_range(2, 400);
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 7)       rep = 16'($urandom_range(0, 3));
    else if (pick < 9)  rep = 16'($urandom_range(4, 20));
    else                rep = 16'($urandom());
    write_regs(dur, rep, 1'($urandom_range(0, 1)),
               eaft_pkg::curve_e'($urandom_range(0, 3)));
    idle_on = ($urandom_range(0, 3) != 0);
    now_t   = ($urandom_range(0, 2) == 0) ? $urandom() : now_t + time_step(dur);
    send_word(eaft_pkg::OP_START, now_t);
    n_words = $urandom_range(15, 40);
    for (int i = 0; i < n_words; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_word(eaft_pkg::op_e'($urandom_range(0, 3)), $urandom());
      end else if (pick < 9) begin
        send_word(eaft_pkg::OP_STOP, now_t);
      end else if (pick < 17) begin
        now_t = now_t + time_step(dur);
        send_word(eaft_pkg::OP_START, now_t);
      end else if (pick < 20) begin
        send_word(eaft_pkg::OP_NOP, now_t);
      end else begin
        now_t = now_t + time_step(dur);
        send_word(eaft_pkg::OP_TICK, now_t);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_write_i   = 1'b0;
    cfg_index_i   = eaft_pkg::REG_DURATION;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    operation_i   = eaft_pkg::OP_NOP;
    now_ticks_i   = '0;
    idle_on       = 1'b1;
    now_t         = '0;
    words_sent    = 0;
    settings_used = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_words();
    while (words_sent < WORD_TARGET) random_phase();
    drain();

    $display("sent %0d words (start, tick, stop, no-op) over %0d register settings",
             words_sent, settings_used);
    $display("checked %0d result words, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("eased_animation_frame_timer_core_tb: done, clean");
    end else begin
      $display("eased_animation_frame_timer_core_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: eased_animation_frame_timer_core.f
rtl/eaft_pkg.sv
rtl/eased_animation_frame_timer_core.sv
rtl/eaft_checker.sv
verif/eaft_frame_checker.sv
verif/eased_animation_frame_timer_core_tb.sv
